// ===== src/integer_interval_unit_top_defines.svh =====
// Assertion helpers for the checker file of this block.
`ifndef INTEGER_INTERVAL_UNIT_TOP_DEFINES_SVH
`define INTEGER_INTERVAL_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IIU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IIU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/iiu_pkg.sv =====
package iiu_pkg;

  // Internal arithmetic width: wide enough for every sum and difference of
  // 32-bit endpoints, including twice a point minus an endpoint.
  localparam int IW = 36;

  localparam int IN_TDATA_W  = 192;
  localparam int OUT_TDATA_W = 72;
  localparam int FUNC_W      = 4;

  typedef enum logic [3:0] {
    FN_MINMAX     = 4'd0,
    FN_MINSIZE    = 4'd1,
    FN_MAXSIZE    = 4'd2,
    FN_HAS_POINT  = 4'd3,
    FN_HAS_IVAL   = 4'd4,
    FN_OVERLAPS   = 4'd5,
    FN_DILATE     = 4'd6,
    FN_SHIFT      = 4'd7,
    FN_REFLECT    = 4'd8,
    FN_EXP_POINT  = 4'd9,
    FN_EXP_IVAL   = 4'd10,
    FN_CLIP       = 4'd11,
    FN_EQUAL      = 4'd12
  } iiu_func_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_MIN  = 2'd1,
    ERR_MAX  = 2'd2,
    ERR_SIZE = 2'd3
  } iiu_err_t;

  // How the back end forms the result interval.
  typedef enum logic [1:0] {
    K_NONE  = 2'd0,
    K_BUILD = 2'd1,
    K_PASS  = 2'd2
  } iiu_kind_t;

  typedef struct packed {
    iiu_kind_t               kind;
    logic signed [IW-1:0]    lo;
    logic signed [IW-1:0]    hi;
    logic        [30:0]      psize;
    logic                    flag;
  } iiu_s2_t;

  function automatic logic signed [IW-1:0] smin(input logic signed [IW-1:0] a,
                                                input logic signed [IW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [IW-1:0] smax(input logic signed [IW-1:0] a,
                                                input logic signed [IW-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== src/iiu_build.sv =====
module iiu_build
  import iiu_pkg::*;
#(
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  iiu_s2_t       s2,
  output logic          out_valid,
  output logic [31:0]   res_min,
  output logic [30:0]   res_size,
  output logic          flag,
  output iiu_err_t      error
);

  localparam int CHK = (ELEMENT_WIDTH < IW) ? ELEMENT_WIDTH : IW;

  // A value is in the element range when all bits from the element sign bit
  // upward agree.
  function automatic logic in_rng(input logic signed [IW-1:0] x);
    logic [IW-CHK:0] top_bits;
    top_bits = x[IW-1:CHK-1];
    return (top_bits == '0) || (top_bits == '1);
  endfunction

  logic signed [IW-1:0] lo_s, hi_s;
  logic signed [IW-1:0] sz_nxt;

  logic                 v3_r;
  iiu_kind_t            kind3_r;
  logic                 lt3_r, lo_ok3_r, hi_ok3_r, flag3_r;
  logic signed [IW-1:0] lo3_r, sz3_r;
  logic [30:0]          psize3_r;

  logic                 vo_r;
  logic [31:0]          min_o_r;
  logic [30:0]          size_o_r;
  logic                 flag_o_r;
  iiu_err_t             err_o_r;

  logic signed [IW-1:0] lo_fin, sz_fin;
  iiu_err_t             err_fin;

  assign lo_s   = s2.lo;
  assign hi_s   = s2.hi;
  assign sz_nxt = hi_s - lo_s + IW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v3_r <= in_valid;
      vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind3_r  <= s2.kind;
      lt3_r    <= hi_s < lo_s;
      lo_ok3_r <= in_rng(lo_s);
      hi_ok3_r <= in_rng(hi_s);
      lo3_r    <= lo_s;
      sz3_r    <= sz_nxt;
      psize3_r <= s2.psize;
      flag3_r  <= s2.flag;
    end
  end

  always_comb begin
    lo_fin  = '0;
    sz_fin  = '0;
    err_fin = ERR_NONE;
    unique case (kind3_r)
      K_BUILD: begin
        if (lt3_r) begin
          err_fin = ERR_NONE;
        end else if (!lo_ok3_r) begin
          err_fin = ERR_MIN;
        end else if (!hi_ok3_r) begin
          err_fin = ERR_MAX;
        end else if (!in_rng(sz3_r)) begin
          err_fin = ERR_SIZE;
        end else begin
          lo_fin = lo3_r;
          sz_fin = sz3_r;
        end
      end
      K_PASS: begin
        lo_fin = lo3_r;
        sz_fin = {{(IW-31){1'b0}}, psize3_r};
      end
      default: begin
        lo_fin = '0;
      end
    endcase
    // An empty result always reports a zero minimum.
    if (sz_fin == '0) begin
      lo_fin = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      min_o_r  <= lo_fin[31:0];
      size_o_r <= sz_fin[30:0];
      flag_o_r <= flag3_r;
      err_o_r  <= err_fin;
    end
  end

  assign out_valid = vo_r;
  assign res_min   = min_o_r;
  assign res_size  = size_o_r;
  assign flag      = flag_o_r;
  assign error     = err_o_r;

endmodule

// ===== src/integer_interval_unit_top.sv =====
// Integer interval unit. Each input word carries an operation code in
// in_tuser and two intervals (minimum and size, size zero meaning empty) plus
// two values in in_tdata; each accepted word yields exactly one output word
// holding the result interval, a boolean flag and an overflow code. The unit
// is a four-stage pipeline: operand widening and maxima, operation select,
// endpoint range checks and size, then result formation. It accepts one word
// every cycle while in_tready is high. The whole pipeline advances together,
// so in_tready drops only while a finished word sits on the output and
// out_tready is low.
module integer_interval_unit_top
  import iiu_pkg::*;
#(
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // a_min[31:0], a_size[62:32], b_min[94:63], b_size[125:95],
  // value_a[157:126], value_b[189:158], zero fill[191:190]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // func[3:0]
  input  logic [FUNC_W-1:0]      in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // res_min[31:0], res_size[62:32], flag[63], error[65:64], zero fill[71:66]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic en;

  logic                 v1_r, v2_r;
  iiu_func_t            func1_r;
  logic signed [IW-1:0] amin1_r, amax1_r, bmin1_r, bmax1_r, va1_r, vb1_r;
  logic [30:0]          asz1_r, bsz1_r;
  logic                 ae1_r, be1_r;

  logic signed [IW-1:0] amin_in, bmin_in, va_in, vb_in;
  logic signed [IW-1:0] amax1_nxt, bmax1_nxt;
  logic [30:0]          asz_in, bsz_in;

  iiu_s2_t              s2_nxt, s2_r;
  logic signed [IW-1:0] va2x;

  logic                 res_valid;
  logic [31:0]          res_min;
  logic [30:0]          res_size;
  logic                 res_flag;
  iiu_err_t             res_err;

  assign en        = !res_valid || out_tready;
  assign in_tready = en;

  assign amin_in = {{(IW-32){in_tdata[31]}},  in_tdata[31:0]};
  assign asz_in  = in_tdata[62:32];
  assign bmin_in = {{(IW-32){in_tdata[94]}},  in_tdata[94:63]};
  assign bsz_in  = in_tdata[125:95];
  assign va_in   = {{(IW-32){in_tdata[157]}}, in_tdata[157:126]};
  assign vb_in   = {{(IW-32){in_tdata[189]}}, in_tdata[189:158]};

  assign amax1_nxt = amin_in + {{(IW-31){1'b0}}, asz_in} - IW'(1);
  assign bmax1_nxt = bmin_in + {{(IW-31){1'b0}}, bsz_in} - IW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func1_r <= iiu_func_t'(in_tuser);
      amin1_r <= amin_in;
      amax1_r <= amax1_nxt;
      bmin1_r <= bmin_in;
      bmax1_r <= bmax1_nxt;
      va1_r   <= va_in;
      vb1_r   <= vb_in;
      asz1_r  <= asz_in;
      bsz1_r  <= bsz_in;
      ae1_r   <= (asz_in == '0);
      be1_r   <= (bsz_in == '0);
    end
  end

  assign va2x = va1_r <<< 1;

  always_comb begin
    s2_nxt = '{kind: K_NONE, lo: '0, hi: '0, psize: '0, flag: 1'b0};
    unique case (func1_r)
      FN_MINMAX: begin
        s2_nxt.kind = K_BUILD;
        s2_nxt.lo   = va1_r;
        s2_nxt.hi   = vb1_r;
      end
      FN_MINSIZE: begin
        if (!vb1_r[IW-1] && (vb1_r != '0)) begin
          s2_nxt.kind = K_BUILD;
          s2_nxt.lo   = va1_r;
          s2_nxt.hi   = va1_r + vb1_r - IW'(1);
        end
      end
      FN_MAXSIZE: begin
        if (!vb1_r[IW-1] && (vb1_r != '0)) begin
          s2_nxt.kind = K_BUILD;
          s2_nxt.lo   = va1_r - vb1_r + IW'(1);
          s2_nxt.hi   = va1_r;
        end
      end
      FN_HAS_POINT: begin
        s2_nxt.flag = !ae1_r && (va1_r >= amin1_r) && (va1_r <= amax1_r);
      end
      FN_HAS_IVAL: begin
        s2_nxt.flag = be1_r || (!ae1_r && (bmin1_r >= amin1_r) && (bmax1_r <= amax1_r));
      end
      FN_OVERLAPS: begin
        s2_nxt.flag = !ae1_r && !be1_r && !((amin1_r > bmax1_r) || (amax1_r < bmin1_r));
      end
      FN_DILATE: begin
        if (!ae1_r) begin
          s2_nxt.kind = K_BUILD;
          s2_nxt.lo   = amin1_r - va1_r;
          s2_nxt.hi   = amax1_r + va1_r;
        end
      end
      FN_SHIFT: begin
        if (!ae1_r) begin
          s2_nxt.kind = K_BUILD;
          s2_nxt.lo   = amin1_r + va1_r;
          s2_nxt.hi   = amax1_r + va1_r;
        end
      end
      FN_REFLECT: begin
        if (!ae1_r) begin
          s2_nxt.kind = K_BUILD;
          s2_nxt.lo   = va2x - amax1_r;
          s2_nxt.hi   = va2x - amin1_r;
        end
      end
      FN_EXP_POINT: begin
        s2_nxt.kind = K_BUILD;
        if (ae1_r) begin
          s2_nxt.lo = va1_r;
          s2_nxt.hi = va1_r;
        end else begin
          s2_nxt.lo = smin(va1_r, amin1_r);
          s2_nxt.hi = smax(va1_r, amax1_r);
        end
      end
      FN_EXP_IVAL: begin
        // An empty side leaves the other operand unchanged, unchecked.
        if (be1_r) begin
          s2_nxt.kind  = K_PASS;
          s2_nxt.lo    = amin1_r;
          s2_nxt.psize = asz1_r;
        end else if (ae1_r) begin
          s2_nxt.kind  = K_PASS;
          s2_nxt.lo    = bmin1_r;
          s2_nxt.psize = bsz1_r;
        end else begin
          s2_nxt.kind = K_BUILD;
          s2_nxt.lo   = smin(amin1_r, bmin1_r);
          s2_nxt.hi   = smax(amax1_r, bmax1_r);
        end
      end
      FN_CLIP: begin
        if (!ae1_r && !be1_r) begin
          s2_nxt.kind = K_BUILD;
          s2_nxt.lo   = smax(amin1_r, bmin1_r);
          s2_nxt.hi   = smin(amax1_r, bmax1_r);
        end
      end
      FN_EQUAL: begin
        s2_nxt.flag = (asz1_r == bsz1_r) && (ae1_r || (amin1_r == bmin1_r));
      end
      default: begin
        s2_nxt.kind = K_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

  iiu_build #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_build (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .s2        (s2_r),
    .out_valid (res_valid),
    .res_min   (res_min),
    .res_size  (res_size),
    .flag      (res_flag),
    .error     (res_err)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {6'b0, res_err, res_flag, res_size, res_min};

endmodule

// ===== src/iiu_checker.sv =====
`include "integer_interval_unit_top_defines.svh"

module iiu_checker
  import iiu_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A held output word stays offered until it is taken.
  `IIU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "output word dropped while stalled")

  // The pipeline refuses new words only while a result is blocked.
  `IIU_ASSERT_NOW(a_ready_rule, clk, rst_n, 1'b1, in_tready == (!out_tvalid || out_tready), "input ready does not follow output backpressure")

  // Any overflow code comes with the empty interval at minimum zero.
  `IIU_ASSERT_NOW(a_err_empty, clk, rst_n, out_tvalid && (out_tdata[65:64] != 2'd0), out_tdata[62:0] == 63'd0, "overflow result is not empty")

  // Boolean answers carry no interval and no error.
  `IIU_ASSERT_NOW(a_flag_clean, clk, rst_n, out_tvalid && out_tdata[63], (out_tdata[62:0] == 63'd0) && (out_tdata[65:64] == 2'd0), "flag result carries interval data")

endmodule

bind integer_interval_unit_top iiu_checker u_iiu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/tb_top.sv =====
module tb_top;
  import iiu_pkg::*;

  localparam int ELEMENT_WIDTH = 32;
  localparam longint ELEM_MAX = (longint'(1) << (ELEMENT_WIDTH - 1)) - 1;
  localparam longint ELEM_MIN = -ELEM_MAX - 1;

  localparam logic signed [31:0] VAL_LOW  = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_HIGH = 32'sh7FFF_FFFF;
  localparam logic [30:0]        SIZE_FULL = 31'h7FFF_FFFF;
  localparam int FN_FIRST_UNUSED = FN_EQUAL + 1;
  localparam int FN_LAST_CODE    = 15;

  localparam int RANDOM_WORDS   = 1250;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [3:0]         func;
    logic signed [31:0] a_min;
    logic [30:0]        a_size;
    logic signed [31:0] b_min;
    logic [30:0]        b_size;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
  } ival_op_t;

  typedef struct {
    logic signed [31:0] res_min;
    logic [30:0]        res_size;
    logic               flag;
    iiu_err_t           error;
  } ival_result_t;

  typedef struct {
    longint   lo;
    longint   size;
    iiu_err_t err;
  } span_t;

  typedef enum int {RX_STREAM, RX_SPARSE, RX_PERIODIC, RX_HEAVY} stall_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]      in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  ival_result_t due_results[$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int unsigned rx_count = 0;
  stall_mode_t rx_mode = RX_STREAM;

  integer_interval_unit_top #(
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit fits_elem(longint x);
    return x >= ELEM_MIN && x <= ELEM_MAX;
  endfunction

  // Forms [lo, hi] with the range checks in order minimum, maximum, size.
  function automatic span_t span_from(longint lo, longint hi);
    span_t s;
    s.lo = 0;
    s.size = 0;
    s.err = ERR_NONE;
    if (hi < lo) return s;
    if (!fits_elem(lo)) begin
      s.err = ERR_MIN;
      return s;
    end
    if (!fits_elem(hi)) begin
      s.err = ERR_MAX;
      return s;
    end
    if (!fits_elem(hi - lo + 1)) begin
      s.err = ERR_SIZE;
      return s;
    end
    s.lo = lo;
    s.size = hi - lo + 1;
    return s;
  endfunction

  function automatic ival_result_t interval_result(ival_op_t op);
    longint amin, asz, amax, bmin, bsz, bmax, va, vb;
    bit aempty, bempty;
    span_t s;
    ival_result_t r;
    amin = op.a_min;
    asz  = op.a_size;
    bmin = op.b_min;
    bsz  = op.b_size;
    va   = op.value_a;
    vb   = op.value_b;
    amax = amin + asz - 1;
    bmax = bmin + bsz - 1;
    aempty = (asz == 0);
    bempty = (bsz == 0);
    s.lo = 0;
    s.size = 0;
    s.err = ERR_NONE;
    r.flag = 1'b0;
    case (op.func)
      FN_MINMAX:    s = span_from(va, vb);
      FN_MINSIZE:   if (vb > 0) s = span_from(va, va + vb - 1);
      FN_MAXSIZE:   if (vb > 0) s = span_from(va - vb + 1, va);
      FN_HAS_POINT: r.flag = !aempty && va >= amin && va <= amax;
      FN_HAS_IVAL:  r.flag = bempty || (!aempty && bmin >= amin && bmax <= amax);
      FN_OVERLAPS:  r.flag = !aempty && !bempty && !(amin > bmax || amax < bmin);
      FN_DILATE:    if (!aempty) s = span_from(amin - va, amax + va);
      FN_SHIFT:     if (!aempty) s = span_from(amin + va, amax + va);
      FN_REFLECT:   if (!aempty) s = span_from(2 * va - amax, 2 * va - amin);
      FN_EXP_POINT: begin
        if (aempty) s = span_from(va, va);
        else s = span_from((va < amin) ? va : amin, (va > amax) ? va : amax);
      end
      FN_EXP_IVAL: begin
        if (bempty) begin
          s.lo = amin;
          s.size = asz;
        end else if (aempty) begin
          s.lo = bmin;
          s.size = bsz;
        end else begin
          s = span_from((amin < bmin) ? amin : bmin, (amax > bmax) ? amax : bmax);
        end
      end
      FN_CLIP: begin
        if (!aempty && !bempty)
          s = span_from((amin > bmin) ? amin : bmin, (amax < bmax) ? amax : bmax);
      end
      FN_EQUAL:     r.flag = (asz == bsz) && (aempty || amin == bmin);
      default: ;
    endcase
    if (s.size == 0) s.lo = 0;
    r.res_min  = s.lo[31:0];
    r.res_size = s.size[30:0];
    r.error    = s.err;
    return r;
  endfunction

  function automatic ival_op_t interval_op(logic [3:0] func,
                                           logic signed [31:0] a_min, logic [30:0] a_size,
                                           logic signed [31:0] b_min, logic [30:0] b_size,
                                           logic signed [31:0] value_a,
                                           logic signed [31:0] value_b);
    ival_op_t op;
    op.func = func;
    op.a_min = a_min;
    op.a_size = a_size;
    op.b_min = b_min;
    op.b_size = b_size;
    op.value_a = value_a;
    op.value_b = value_b;
    return op;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return $urandom_range(0, 64) - 32;
      3: return VAL_HIGH - $urandom_range(0, 16);
      4: return VAL_LOW + $urandom_range(0, 16);
      default: return $urandom_range(0, 4000) - 2000;
    endcase
  endfunction

  function automatic logic [30:0] pick_size();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return $urandom_range(1, 16);
      2: return $urandom_range(1, 1 << 20);
      3, 4: return $urandom;
      default: return SIZE_FULL - $urandom_range(0, 16);
    endcase
  endfunction

  // Operands are mostly related to each other so that containment, overlap,
  // equality and clipping see both answers often.
  function automatic ival_op_t random_op();
    ival_op_t op;
    if ($urandom_range(0, 9) == 0) op.func = $urandom_range(FN_FIRST_UNUSED, FN_LAST_CODE);
    else op.func = $urandom_range(0, FN_EQUAL);
    op.a_min = pick_value();
    op.a_size = pick_size();
    case ($urandom_range(0, 3))
      0: begin
        op.b_min = pick_value();
        op.b_size = pick_size();
      end
      1: begin
        op.b_min = op.a_min;
        op.b_size = op.a_size;
      end
      default: begin
        op.b_min = op.a_min + $urandom_range(0, 40) - 20;
        op.b_size = ($urandom_range(0, 1) == 0) ? op.a_size + $urandom_range(0, 8) - 4
                                                : pick_size();
      end
    endcase
    case ($urandom_range(0, 2))
      0: op.value_a = pick_value();
      1: op.value_a = op.a_min + $urandom_range(0, 20) - 10;
      default: op.value_a = op.a_min + op.a_size - 1 + $urandom_range(0, 20) - 10;
    endcase
    if ($urandom_range(0, 1) == 0) op.value_b = pick_value();
    else op.value_b = op.value_a + $urandom_range(0, 104) - 4;
    return op;
  endfunction

  // Sends one word; the sender runs in bursts with random gaps between them.
  task automatic send_word(input ival_op_t op);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tuser  <= op.func;
    in_tdata  <= {2'b00, op.value_b, op.value_a, op.b_size, op.b_min, op.a_size, op.a_min};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic test_construction();
    send_word(interval_op(FN_MINMAX, 0, 0, 0, 0, VAL_LOW, VAL_HIGH));
    send_word(interval_op(FN_MINMAX, 0, 0, 0, 0, 5, 4));
    send_word(interval_op(FN_MINSIZE, 0, 0, 0, 0, VAL_HIGH, 2));
    send_word(interval_op(FN_MINSIZE, 0, 0, 0, 0, 7, VAL_LOW));
    send_word(interval_op(FN_MAXSIZE, 0, 0, 0, 0, VAL_LOW, 2));
    send_word(interval_op(FN_MAXSIZE, 0, 0, 0, 0, 100, 10));
  endtask

  task automatic test_membership();
    send_word(interval_op(FN_HAS_POINT, 5, 0, 0, 0, 5, 0));
    send_word(interval_op(FN_HAS_POINT, -10, 5, 0, 0, -6, 0));
    send_word(interval_op(FN_HAS_IVAL, 3, 0, 9, 0, 0, 0));
    send_word(interval_op(FN_HAS_IVAL, 3, 0, 9, 2, 0, 0));
    send_word(interval_op(FN_OVERLAPS, 0, 10, 9, 5, 0, 0));
    send_word(interval_op(FN_EQUAL, 3, 0, -8, 0, 0, 0));
  endtask

  task automatic test_transforms();
    send_word(interval_op(FN_DILATE, 4, 0, 0, 0, 3, 0));
    send_word(interval_op(FN_DILATE, 0, 4, 0, 0, -2, 0));
    send_word(interval_op(FN_DILATE, VAL_LOW, 10, 0, 0, 1, 0));
    send_word(interval_op(FN_SHIFT, 1, 1, 0, 0, VAL_HIGH, 0));
    // The operand reaches far past the element range and is used as given.
    send_word(interval_op(FN_SHIFT, VAL_HIGH, SIZE_FULL, 0, 0, VAL_LOW, 0));
    send_word(interval_op(FN_REFLECT, 0, 1, 0, 0, VAL_LOW, 0));
  endtask

  task automatic test_expand_and_clip();
    send_word(interval_op(FN_EXP_POINT, 11, 0, 0, 0, VAL_HIGH, 0));
    send_word(interval_op(FN_EXP_POINT, VAL_LOW, 1, 0, 0, VAL_HIGH, 0));
    send_word(interval_op(FN_EXP_IVAL, VAL_HIGH, SIZE_FULL, 40, 0, 0, 0));
    send_word(interval_op(FN_EXP_IVAL, -40, 0, 12, 3, 0, 0));
    send_word(interval_op(FN_CLIP, 0, 5, 10, 5, 0, 0));
    send_word(interval_op(FN_CLIP, 0, 0, 0, 5, 0, 0));
  endtask

  task automatic test_unused_codes();
    for (int c = FN_FIRST_UNUSED; c <= FN_LAST_CODE; c++)
      send_word(interval_op(4'(c), VAL_HIGH, SIZE_FULL, VAL_LOW, SIZE_FULL, -1, -1));
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < RANDOM_WORDS; i++)
      send_word(random_op());
  endtask

  // The receiver switches at random between stall patterns.
  always @(posedge clk) begin
    rx_count <= rx_count + 1;
    if (rx_count % 256 == 0) rx_mode <= stall_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_STREAM:   out_tready <= 1'b1;
      RX_SPARSE:   out_tready <= ($urandom_range(0, 9) >= 3);
      RX_PERIODIC: out_tready <= (rx_count % 7 >= 3);
      default:     out_tready <= ($urandom_range(0, 9) >= 7);
    endcase
  end

  always @(posedge clk) begin : scoreboard
    ival_op_t     seen;
    ival_result_t want;
    ival_result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        seen.func    = in_tuser;
        seen.a_min   = in_tdata[31:0];
        seen.a_size  = in_tdata[62:32];
        seen.b_min   = in_tdata[94:63];
        seen.b_size  = in_tdata[125:95];
        seen.value_a = in_tdata[157:126];
        seen.value_b = in_tdata[189:158];
        due_results.push_back(interval_result(seen));
      end
      if (out_tvalid && out_tready) begin
        got.res_min  = out_tdata[31:0];
        got.res_size = out_tdata[62:32];
        got.flag     = out_tdata[63];
        got.error    = iiu_err_t'(out_tdata[65:64]);
        if (due_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result word with none expected: min=%0d size=%0d flag=%0b err=%0d",
                   $time, got.res_min, got.res_size, got.flag, got.error);
        end else begin
          want = due_results.pop_front();
          if (got.res_min !== want.res_min || got.res_size !== want.res_size ||
              got.flag !== want.flag || got.error !== want.error) begin
            mismatch_count++;
            $display("%0t: expected min=%0d size=%0d flag=%0b err=%0d", $time,
                     want.res_min, want.res_size, want.flag, want.error);
            $display("%0t: actual   min=%0d size=%0d flag=%0b err=%0d", $time,
                     got.res_min, got.res_size, got.flag, got.error);
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_construction();
    test_membership();
    test_transforms();
    test_expand_and_clip();
    test_unused_codes();
    test_random_mix();
    in_tvalid <= 1'b0;
    // Let the scoreboard record the last accepted word before draining.
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/iiu_pkg.sv
src/iiu_build.sv
src/integer_interval_unit_top.sv
src/iiu_checker.sv
tb/tb_top.sv
